// File: src/ggc_pkg.sv
// Package for the greedy graph coloring block: sizes, codes and beat types.
// No dependencies.
`default_nettype none
package ggc_pkg;
    localparam int MaxVertices = 1024;
    localparam int MaxEdges    = 4096;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int CW = VW + 1;

    typedef logic [1:0] t_mode;
    localparam t_mode ModeAdd    = 2'd0;
    localparam t_mode ModeRun    = 2'd1;
    localparam t_mode ModeRead   = 2'd2;
    localparam t_mode ModeUnused = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status StOk    = 2'd0;
    localparam t_status StFull  = 2'd1;
    localparam t_status StRange = 2'd2;

    localparam logic [0:0] RegVertexCount  = 1'd0;
    localparam logic [0:0] RegReverseOrder = 1'd1;

    typedef struct packed {
        t_mode       mode;
        logic [9:0]  end_a;
        logic [9:0]  end_b;
        logic [9:0]  query_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [10:0] color_count;
        logic [9:0]  vertex_color;
        t_status     status;
    } t_out_beat;
endpackage
`default_nettype wire

// File: src/ggc_stream_if.sv
// Valid/ready channels: one carrying a t_in_beat, one carrying a t_out_beat.
// Depends on ggc_pkg.
`default_nettype none
interface ggc_in_if;
    logic valid;
    logic ready;
    ggc_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ggc_out_if;
    logic valid;
    logic ready;
    ggc_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/greedy_graph_coloring.sv
// Greedy graph coloring: edge store, color and mark memories, run sequencer.
// Depends on ggc_pkg and ggc_stream_if.
// Add: result registered the cycle after accept. Read: result registered from S_RDQ.
// Run: each vertex scans all edges, marks the colors of already colored neighbours and
// picks the first free color. Beats are taken only in S_IDLE with no result pending.
// Synchronous active-low reset clears registers, then an S_INIT pass clears the marks.
`default_nettype none
module greedy_graph_coloring (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ggc_in_if.sink    i_in,
    ggc_out_if.source o_out,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int VW = ggc_pkg::VW;
    localparam int EW = ggc_pkg::EW;
    localparam int CW = ggc_pkg::CW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDQ   = 9'b000000010,
        S_VSTRT = 9'b000000100,
        S_ESCAN = 9'b000001000,
        S_ECHK  = 9'b000010000,
        S_FSCAN = 9'b000100000,
        S_INIT  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_RDW   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [10:0] r_vcount;
    logic        r_rev;
    logic [EW:0] r_etotal;
    logic [CW-1:0] r_used;
    logic [VW:0]  r_vi;
    logic [VW-1:0] r_v;
    logic [EW:0] r_k;
    logic [CW-1:0] r_ci;
    logic [VW-1:0] r_qv;
    logic          r_ovalid;
    ggc_pkg::t_out_beat r_obeat;
    logic [10:0]   r_run_n;
    logic          r_fpend;
    logic          r_found;
    logic [CW-1:0] r_pick;

    logic [2*VW-1:0] edge_mem [ggc_pkg::MaxEdges];
    logic [VW-1:0]   color_mem [ggc_pkg::MaxVertices];
    logic            mark_mem [ggc_pkg::MaxVertices];
    logic [2*VW-1:0] r_edata;
    logic [VW-1:0]   r_cdata;
    logic            r_mdata;
    logic            r_epend;
    logic [VW-1:0]   r_other;

    logic [10:0] live_n;
    logic [EW-1:0] e_raddr;
    logic [VW-1:0] c_raddr;
    logic [VW-1:0] e_a, e_b;
    logic          nb_colored;
    logic [VW-1:0] m_prev;
    logic [CW-1:0] pick_final;
    ggc_pkg::t_in_beat ib;

    assign live_n = (r_vcount > 11'd1024) ? 11'd1024 : r_vcount;
    assign ib = i_in.data;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_obeat;
    assign pready = 1'b1;
    assign e_a = r_edata[2*VW-1:VW];
    assign e_b = r_edata[VW-1:0];
    assign e_raddr = r_k[EW-1:0];
    assign nb_colored = r_rev ? ((r_other > r_v) && ({1'b0, r_other} < live_n))
                              : (r_other < r_v);
    assign m_prev = r_ci[VW-1:0] - 1'b1;
    assign pick_final = (r_fpend && !r_mdata && !r_found) ? {1'b0, m_prev} : r_pick;

    always_comb begin
        c_raddr = r_other;
        if (r_state == S_IDLE) c_raddr = ib.query_vertex;
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == ggc_pkg::RegReverseOrder) prdata = {31'd0, r_rev};
        else prdata = {21'd0, r_vcount};
    end

    always_ff @(posedge i_clk) begin
        r_edata <= edge_mem[e_raddr];
        r_cdata <= color_mem[c_raddr];
        r_mdata <= mark_mem[r_ci[VW-1:0]];
        if (r_state == S_IDLE && i_in.valid && !r_ovalid && ib.mode == ggc_pkg::ModeAdd
            && {1'b0, ib.end_a} < live_n && {1'b0, ib.end_b} < live_n
            && !r_etotal[EW])
            edge_mem[r_etotal[EW-1:0]] <= {ib.end_a, ib.end_b};
        if (r_state == S_FSCAN && r_ci >= r_used)
            color_mem[r_v] <= pick_final[VW-1:0];
        if (r_state == S_ECHK && r_epend && nb_colored)
            mark_mem[r_cdata] <= 1'b1;
        else if (r_state == S_FSCAN && r_fpend)
            mark_mem[m_prev] <= 1'b0;
        else if (r_state == S_INIT)
            mark_mem[r_ci[VW-1:0]] <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_vcount <= 11'd1;
            r_rev <= 1'b0;
            r_etotal <= '0;
            r_used <= '0;
            r_ovalid <= 1'b0;
            r_run_n <= '0;
            r_fpend <= 1'b0;
            r_found <= 1'b0;
            r_pick <= '0;
            r_epend <= 1'b0;
            r_vi <= '0; r_v <= '0; r_k <= '0; r_ci <= '0; r_qv <= '0;
            r_other <= '0;
            r_obeat <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ggc_pkg::RegReverseOrder) r_rev <= pwdata[0];
                else r_vcount <= pwdata[10:0];
            end
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    if (r_ci[VW-1:0] == '1) begin
                        r_ci <= '0;
                        r_state <= S_IDLE;
                    end else r_ci <= r_ci + 1'b1;
                end
                S_IDLE: begin
                    if (i_in.valid && !r_ovalid) begin
                        r_obeat.color_count <= r_used;
                        r_obeat.vertex_color <= '0;
                        r_obeat.status <= ggc_pkg::StOk;
                        r_qv <= ib.query_vertex;
                        case (ib.mode)
                            ggc_pkg::ModeAdd: begin
                                if ({1'b0, ib.end_a} >= live_n || {1'b0, ib.end_b} >= live_n)
                                    r_obeat.status <= ggc_pkg::StRange;
                                else if (r_etotal[EW])
                                    r_obeat.status <= ggc_pkg::StFull;
                                else r_etotal <= r_etotal + 1'b1;
                                r_ovalid <= 1'b1;
                            end
                            ggc_pkg::ModeRun: begin
                                r_run_n <= live_n;
                                r_used <= '0;
                                r_vi <= '0;
                                r_state <= S_VSTRT;
                            end
                            ggc_pkg::ModeRead: r_state <= S_RDQ;
                            default: r_ovalid <= 1'b1;
                        endcase
                    end
                end
                S_RDQ: begin
                    if ({1'b0, r_qv} >= live_n) r_obeat.status <= ggc_pkg::StRange;
                    else if ({1'b0, r_qv} < r_run_n) r_obeat.vertex_color <= r_cdata;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_VSTRT: begin
                    if (r_vi[VW:0] >= live_n[VW:0]) begin
                        r_state <= S_OUT;
                    end else begin
                        r_v <= r_rev ? VW'(live_n - 11'd1 - 11'(r_vi)) : r_vi[VW-1:0];
                        r_k <= '0;
                        r_epend <= 1'b0;
                        r_state <= S_ESCAN;
                    end
                end
                S_ESCAN: begin
                    // edge read issued at r_k; data arrives next cycle
                    if (r_epend) begin
                        if (e_a == r_v) r_other <= e_b;
                        else r_other <= e_a;
                        r_state <= (e_a == r_v || e_b == r_v) ? S_ECHK : S_ESCAN;
                        r_epend <= 1'b0;
                        if (!(e_a == r_v || e_b == r_v)) r_k <= r_k + 1'b1;
                    end else if (r_k >= r_etotal) begin
                        r_ci <= '0;
                        r_fpend <= 1'b0;
                        r_found <= 1'b0;
                        r_pick <= r_used;
                        r_state <= S_FSCAN;
                    end else begin
                        r_epend <= 1'b1;
                    end
                end
                S_ECHK: begin
                    // color memory read at r_other landed in r_cdata
                    if (!r_epend) r_epend <= 1'b1;
                    else begin
                        r_epend <= 1'b0;
                        r_k <= r_k + 1'b1;
                        r_state <= S_ESCAN;
                    end
                end
                S_FSCAN: begin
                    // scan and clear marks below r_used; keep the first free color
                    if (r_fpend && !r_mdata && !r_found) begin
                        r_pick <= {1'b0, m_prev};
                        r_found <= 1'b1;
                    end
                    if (r_ci < r_used) begin
                        r_ci <= r_ci + 1'b1;
                        r_fpend <= 1'b1;
                    end else begin
                        if (pick_final >= r_used) r_used <= pick_final + 1'b1;
                        r_fpend <= 1'b0;
                        r_vi <= r_vi + 1'b1;
                        r_state <= S_VSTRT;
                    end
                end
                S_OUT: begin
                    r_obeat.color_count <= r_used;
                    r_ovalid <= 1'b1;
                    r_state <= S_RDW;
                end
                S_RDW: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/ggc_checker.sv
// Port-level checks for greedy_graph_coloring, bound to the top level.
// Depends on ggc_pkg and the top level's ports.
`default_nettype none
module ggc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] out_status,
    input wire logic [9:0] out_color
);
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_status == ggc_pkg::StOk || out_status == ggc_pkg::StFull
                       || out_status == ggc_pkg::StRange)) else $error("bad status");
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_status != ggc_pkg::StOk) |-> out_color == 10'd0)
        else $error("color on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !in_ready) |=> in_valid) else $error("input beat withdrawn");
endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_status(o_out.data.status), .out_color(o_out.data.vertex_color)
);
`default_nettype wire

// File: tb/greedy_graph_coloring_tb.sv
// Testbench for greedy_graph_coloring: a queue-fed driver and a checking monitor,
// with a predictor of the edge store and the coloring pass, and APB register setup.
// Depends on ggc_pkg, ggc_stream_if and the greedy_graph_coloring RTL.
`timescale 1ns / 100ps
module greedy_graph_coloring_tb;
    localparam int WatchLimit = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ggc_in_if  in_ch ();
    ggc_out_if out_ch ();

    greedy_graph_coloring u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [9:0]  edge_a [ggc_pkg::MaxEdges];
    logic [9:0]  edge_b [ggc_pkg::MaxEdges];
    int          edge_total;
    logic [9:0]  vcolor [ggc_pkg::MaxVertices];
    bit          vflag  [ggc_pkg::MaxVertices];
    bit          marks  [ggc_pkg::MaxVertices + 1];
    int          colors_used;
    logic [10:0] cfg_count;
    bit          cfg_reverse;

    ggc_pkg::t_in_beat  pending_beats [$];
    ggc_pkg::t_out_beat expected_beats [$];

    int fail_count;
    int n_add, n_run, n_read, n_other, n_checked;
    int gap_left, burst_left;
    int stall_kind, stall_timer;
    int idle_cycles;
    longint cycle;

    function automatic int live_count();
        return (cfg_count > ggc_pkg::MaxVertices) ? ggc_pkg::MaxVertices : int'(cfg_count);
    endfunction

    function automatic int free_color(int v);
        int i, k, other;
        for (i = 0; i <= colors_used && i <= ggc_pkg::MaxVertices; i++) marks[i] = 0;
        for (k = 0; k < edge_total; k++) begin
            if (edge_a[k] == v) other = edge_b[k];
            else if (edge_b[k] == v) other = edge_a[k];
            else continue;
            if (vflag[other]) marks[vcolor[other]] = 1;
        end
        for (i = 0; i < colors_used; i++)
            if (!marks[i]) return i;
        return colors_used;
    endfunction

    function automatic void color_graph();
        int n, i, v, c;
        n = live_count();
        for (i = 0; i < ggc_pkg::MaxVertices; i++) vflag[i] = 0;
        colors_used = 0;
        for (i = 0; i < n; i++) begin
            v = cfg_reverse ? (n - 1 - i) : i;
            c = free_color(v);
            vcolor[v] = c[9:0];
            vflag[v] = 1;
            if (c >= colors_used) colors_used = c + 1;
        end
    endfunction

    function automatic void predict_beat(ggc_pkg::t_in_beat b);
        ggc_pkg::t_out_beat r;
        int n;
        n = live_count();
        r.vertex_color = '0;
        r.status = ggc_pkg::StOk;
        case (b.mode)
            ggc_pkg::ModeAdd: begin
                n_add++;
                if (b.end_a >= n || b.end_b >= n) r.status = ggc_pkg::StRange;
                else if (edge_total >= ggc_pkg::MaxEdges) r.status = ggc_pkg::StFull;
                else begin
                    edge_a[edge_total] = b.end_a;
                    edge_b[edge_total] = b.end_b;
                    edge_total++;
                end
            end
            ggc_pkg::ModeRun: begin
                n_run++;
                color_graph();
            end
            ggc_pkg::ModeRead: begin
                n_read++;
                if (b.query_vertex >= n) r.status = ggc_pkg::StRange;
                else if (vflag[b.query_vertex]) r.vertex_color = vcolor[b.query_vertex];
            end
            default: n_other++;
        endcase
        r.color_count = colors_used[10:0];
        expected_beats.push_back(r);
    endfunction

    function automatic ggc_pkg::t_in_beat mk(ggc_pkg::t_mode m, int a, int b, int q);
        ggc_pkg::t_in_beat x;
        x.mode = m;
        x.end_a = a[9:0];
        x.end_b = b[9:0];
        x.query_vertex = q[9:0];
        return x;
    endfunction

    function automatic int pick_vertex();
        int n;
        n = live_count();
        if (n > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, n - 1);
        return $urandom_range(0, 1023);
    endfunction

    function automatic ggc_pkg::t_in_beat random_beat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 32) return mk(ggc_pkg::ModeAdd, pick_vertex(), pick_vertex(),
                              $urandom_range(0, 1023));
        if (r < 35) return mk(ggc_pkg::ModeRun, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (r < 88) return mk(ggc_pkg::ModeRead, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), pick_vertex());
        return mk(ggc_pkg::ModeUnused, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            gap_left <= 0;
            burst_left <= 4;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_beat(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_beats.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ggc_pkg::t_out_beat e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_kind <= 0;
            stall_timer <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: %p", out_ch.data);
                    fail_count++;
                end else begin
                    e = expected_beats.pop_front();
                    n_checked++;
                    if (out_ch.data.color_count !== e.color_count) begin
                        $error("color_count expected %0d actual %0d",
                               e.color_count, out_ch.data.color_count);
                        fail_count++;
                    end
                    if (out_ch.data.vertex_color !== e.vertex_color) begin
                        $error("vertex_color expected %0d actual %0d",
                               e.vertex_color, out_ch.data.vertex_color);
                        fail_count++;
                    end
                    if (out_ch.data.status !== e.status) begin
                        $error("status expected %0d actual %0d",
                               e.status, out_ch.data.status);
                        fail_count++;
                    end
                end
            end
            if (stall_timer >= 300) begin
                stall_timer <= 0;
                stall_kind <= $urandom_range(0, 2);
            end else begin
                stall_timer <= stall_timer + 1;
            end
            case (stall_kind)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= (cycle % 7) > 2;
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || in_ch.valid || expected_beats.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        logic [31:0] exp_rd;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == ggc_pkg::RegVertexCount) begin
            cfg_count = val[10:0];
            exp_rd = {21'd0, val[10:0]};
        end else begin
            cfg_reverse = val[0];
            exp_rd = {31'd0, val[0]};
        end
        @(posedge i_clk);
        if (prdata !== exp_rd || pready !== 1'b1) begin
            $error("prdata expected %0h actual %0h", exp_rd, prdata);
            fail_count++;
        end
    endtask

    task automatic set_config(int n, bit rev);
        wait_idle();
        reg_write(ggc_pkg::RegVertexCount, n);
        reg_write(ggc_pkg::RegReverseOrder, {31'd0, rev});
    endtask

    initial begin
        int p, k;
        fail_count = 0;
        n_add = 0; n_run = 0; n_read = 0; n_other = 0; n_checked = 0;
        idle_cycles = 0;
        cycle = 0;
        edge_total = 0;
        colors_used = 0;
        cfg_count = 1;
        cfg_reverse = 0;
        for (k = 0; k < ggc_pkg::MaxVertices; k++) begin
            vflag[k] = 0;
            vcolor[k] = '0;
        end
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, self loop, uncolored and range reads
        set_config(1024, 0);
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 0, 1023, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 1023, 0, 1023));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 682, 341, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 5, 5, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 0, 682, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 1023, 1023, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRun, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 1023));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 682));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 5));
        pending_beats.push_back(mk(ggc_pkg::ModeUnused, 1023, 1023, 1023));
        set_config(2047, 1);
        pending_beats.push_back(mk(ggc_pkg::ModeRun, 1023, 1023, 1023));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 1023));
        set_config(0, 0);
        pending_beats.push_back(mk(ggc_pkg::ModeRun, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 0, 0, 0));
        set_config(3, 1);
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 2, 3, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 1023, 1, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 2));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 1023));
        pending_beats.push_back(mk(ggc_pkg::ModeRun, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 2));

        // random phases on small graphs
        for (p = 0; p < 4; p++) begin
            set_config($urandom_range(2, 12), $urandom_range(0, 1));
            for (k = 0; k < 475; k++) pending_beats.push_back(random_beat());
        end

        // stale edges under a shrunken vertex count, range checks on adds
        set_config(1024, 0);
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 1023, 0, 0));
        set_config(2, 1);
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 1, 1023, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeAdd, 1, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRun, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 0));
        pending_beats.push_back(mk(ggc_pkg::ModeRead, 0, 0, 1));

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d adds, %0d runs, %0d reads, %0d unused-mode beats",
                 n_add, n_run, n_read, n_other);
        $display("checked %0d result beats, edge store ended with %0d edges",
                 n_checked, edge_total);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
